@@ design/rhsc_pkg.sv @@
// Package with the constants, codes and helper functions of the rolling hash core.
`timescale 1ns / 1ps
package rhsc_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int HW          = 30;
    localparam int MUL_STEPS   = 2;
    localparam int MUL_CYC     = HW / MUL_STEPS;
    localparam int LANES       = 4;

    localparam logic [HW:0] MOD_LOW    = 31'd1000000007;
    localparam logic [HW:0] MOD_HIGH   = 31'd1000000009;
    localparam logic [30:0] BASE_RESET = 31'd239;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CMP    = 2'd1;
    localparam logic [1:0] MODE_SUB    = 2'd2;

    localparam logic [1:0] ORD_LESS = 2'd0;
    localparam logic [1:0] ORD_EQ   = 2'd1;
    localparam logic [1:0] ORD_GT   = 2'd2;

    localparam logic REG_HASH_BASE = 1'b0;

    function automatic logic [HW-1:0] reduce_base(input logic [30:0] base,
                                                  input logic [HW:0] m);
        logic [31:0] two_m;
        logic [30:0] v;
        two_m = {m, 1'b0};
        v = base;
        if ({1'b0, v} >= two_m) begin
            v = v - two_m[30:0];
        end else if (v >= m) begin
            v = v - m;
        end
        return v[HW-1:0];
    endfunction

    function automatic logic [HW-1:0] sub_mod(input logic [HW-1:0] x,
                                              input logic [HW-1:0] y,
                                              input logic [HW:0] m);
        logic [HW:0] d;
        d = {1'b0, x} - {1'b0, y};
        if (x < y) begin
            d = d + m;
        end
        return d[HW-1:0];
    endfunction

endpackage

@@ design/rolling_hash_suffix_compare_core.sv @@
// Top level: string store with double-modulus prefix hashes, suffix compare and substring hash.
// Error replies are registered; append and substring hash read the hash memory, then multiply; suffix
// compare runs up to log2(MAX_LEN)+1 binary-search rounds, then may read and compare a char pair.
// Throughput: one item at a time; busy stays high until the result strobe, set by the
// single read port of the hash memory and the 2-bit-per-cycle modular multipliers.
// Reset: synchronous, active low; length cleared, base back to 239; o_valid strobe, no stall.
`timescale 1ns / 1ps
module rolling_hash_suffix_compare_core #(
    parameter int MAX_LEN = rhsc_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic        i_restart,
    input  logic [6:0]  i_char_in,
    input  logic [9:0]  i_first_pos,
    input  logic [9:0]  i_second_pos,
    input  logic [10:0] i_sub_len,
    output logic        o_valid,
    output logic [1:0]  o_order,
    output logic [10:0] o_common_prefix,
    output logic [29:0] o_hash_low_mod,
    output logic [29:0] o_hash_high_mod,
    output logic        o_substrings_equal,
    output logic        o_error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int HW  = rhsc_pkg::HW;
    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int CW  = ((LW > 12) ? LW : 12) + 1;
    localparam int CAW = $clog2(MAX_LEN);
    localparam int NL  = rhsc_pkg::LANES;
    localparam int KW  = $clog2(rhsc_pkg::MUL_CYC + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_LEN);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_APP_RD = 4'd1;
    localparam logic [3:0] S_APP_LD = 4'd2;
    localparam logic [3:0] S_RD_PW  = 4'd3;
    localparam logic [3:0] S_RD_HA  = 4'd4;
    localparam logic [3:0] S_RD_HB  = 4'd5;
    localparam logic [3:0] S_RD_HAL = 4'd6;
    localparam logic [3:0] S_RD_HBL = 4'd7;
    localparam logic [3:0] S_MUL_LD = 4'd8;
    localparam logic [3:0] S_MUL    = 4'd9;
    localparam logic [3:0] S_EVAL   = 4'd10;
    localparam logic [3:0] S_BS     = 4'd11;
    localparam logic [3:0] S_CH_A   = 4'd12;
    localparam logic [3:0] S_CH_B   = 4'd13;
    localparam logic [3:0] S_CH_CMP = 4'd14;

    typedef logic [4*HW-1:0] t_hword;

    t_hword       hmem [MAX_LEN+1];
    logic [6:0]   cmem [MAX_LEN];

    logic [3:0]    r_state, n_state;
    logic [30:0]   r_base;
    logic [LW-1:0] r_n, n_n;
    logic [1:0]    r_mode, n_mode;
    logic [6:0]    r_ch, n_ch;
    logic [LW-1:0] r_a, n_a, r_b, n_b, r_len, n_len;
    logic [LW-1:0] r_lo, n_lo, r_hi, n_hi, r_span, n_span;
    logic [KW-1:0] r_cnt, n_cnt;
    logic [HW-1:0] r_pw_l, n_pw_l, r_pw_h, n_pw_h;
    logic [HW-1:0] r_ha_l, n_ha_l, r_ha_h, n_ha_h, r_hb_l, n_hb_l, r_hb_h, n_hb_h;
    logic [HW-1:0] r_hal_l, n_hal_l, r_hal_h, n_hal_h, r_hbl_l, n_hbl_l, r_hbl_h, n_hbl_h;
    logic [HW-1:0] r_acc [NL];
    logic [HW-1:0] n_acc [NL];
    logic [HW-1:0] r_mpl [NL];
    logic [HW-1:0] n_mpl [NL];
    logic [HW-1:0] r_mcd [NL];
    logic [HW-1:0] n_mcd [NL];
    logic [6:0]    r_ca, n_ca;
    logic          r_valid, n_valid;
    logic [1:0]    r_order, n_order;
    logic [10:0]   r_lcp, n_lcp;
    logic [HW-1:0] r_hl, n_hl, r_hh, n_hh;
    logic          r_eq, n_eq, r_err, n_err;

    t_hword        r_hq;
    logic          r_hq_zero;
    logic [6:0]    r_cq;
    logic [LW-1:0] haddr;
    logic [CAW-1:0] caddr;
    logic          hwe, cwe;
    t_hword        hwdata;

    logic [HW-1:0] q_ph_l, q_ph_h, q_pw_l, q_pw_h;
    logic [HW-1:0] base_l, base_h;
    logic [HW-1:0] step_acc [NL];
    logic [HW-1:0] step_mpl [NL];
    logic [HW-1:0] sa_l, sa_h, sb_l, sb_h;
    logic          all_eq;
    logic [HW:0]   chsum_l, chsum_h;

    logic          accept, cfg_wr;
    logic [CW-1:0] a_c, b_c, sl_c, n_c, mx_c, ln_c, lo_c, hi_c;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == rhsc_pkg::REG_HASH_BASE) ? {1'b0, r_base} : 32'd0;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start & ~busy;

    assign o_valid            = r_valid;
    assign o_order            = r_order;
    assign o_common_prefix    = r_lcp;
    assign o_hash_low_mod     = r_hl;
    assign o_hash_high_mod    = r_hh;
    assign o_substrings_equal = r_eq;
    assign o_error            = r_err;

    assign base_l = rhsc_pkg::reduce_base(r_base, rhsc_pkg::MOD_LOW);
    assign base_h = rhsc_pkg::reduce_base(r_base, rhsc_pkg::MOD_HIGH);

    assign q_ph_l = r_hq_zero ? '0 : r_hq[4*HW-1:3*HW];
    assign q_ph_h = r_hq_zero ? '0 : r_hq[3*HW-1:2*HW];
    assign q_pw_l = r_hq_zero ? HW'(1) : r_hq[2*HW-1:HW];
    assign q_pw_h = r_hq_zero ? HW'(1) : r_hq[HW-1:0];

    assign a_c  = CW'(i_first_pos);
    assign b_c  = CW'(i_second_pos);
    assign sl_c = CW'(i_sub_len);
    assign n_c  = CW'(r_n);
    assign mx_c = (a_c > b_c) ? a_c : b_c;
    assign ln_c = CW'(r_len);
    assign lo_c = CW'(r_lo);
    assign hi_c = CW'(r_hi);

    assign sa_l = rhsc_pkg::sub_mod(r_hal_l, r_acc[0], rhsc_pkg::MOD_LOW);
    assign sa_h = rhsc_pkg::sub_mod(r_hal_h, r_acc[1], rhsc_pkg::MOD_HIGH);
    assign sb_l = rhsc_pkg::sub_mod(r_hbl_l, r_acc[2], rhsc_pkg::MOD_LOW);
    assign sb_h = rhsc_pkg::sub_mod(r_hbl_h, r_acc[3], rhsc_pkg::MOD_HIGH);
    assign all_eq = (sa_l == sb_l) && (sa_h == sb_h);

    always_comb begin
        chsum_l = {1'b0, r_acc[0]} + (HW+1)'(r_ch);
        if (chsum_l >= rhsc_pkg::MOD_LOW) begin
            chsum_l = chsum_l - rhsc_pkg::MOD_LOW;
        end
        chsum_h = {1'b0, r_acc[1]} + (HW+1)'(r_ch);
        if (chsum_h >= rhsc_pkg::MOD_HIGH) begin
            chsum_h = chsum_h - rhsc_pkg::MOD_HIGH;
        end
    end

    // interleaved shift-add modular multiply, two multiplier bits per cycle
    always_comb begin
        logic [HW:0]   acc;
        logic [HW-1:0] mp;
        logic [HW:0]   md;
        for (int l = 0; l < NL; l++) begin
            acc = {1'b0, r_acc[l]};
            mp  = r_mpl[l];
            md  = l[0] ? rhsc_pkg::MOD_HIGH : rhsc_pkg::MOD_LOW;
            for (int s = 0; s < rhsc_pkg::MUL_STEPS; s++) begin
                acc = {acc[HW-1:0], 1'b0};
                if (acc >= md) begin
                    acc = acc - md;
                end
                if (mp[HW-1]) begin
                    acc = acc + {1'b0, r_mcd[l]};
                end
                if (acc >= md) begin
                    acc = acc - md;
                end
                mp = {mp[HW-2:0], 1'b0};
            end
            step_acc[l] = acc[HW-1:0];
            step_mpl[l] = mp;
        end
    end

    always_comb begin
        logic [CW-1:0] t;
        t = '0;
        haddr = r_len;
        caddr = '0;
        unique case (r_state)
            S_APP_RD: haddr = r_n;
            S_RD_HA:  haddr = r_a;
            S_RD_HB:  haddr = r_b;
            S_RD_HAL: begin
                t = CW'(r_a) + ln_c;
                haddr = t[LW-1:0];
            end
            S_RD_HBL: begin
                t = CW'(r_b) + ln_c;
                haddr = t[LW-1:0];
            end
            S_CH_A: begin
                t = CW'(r_a) + lo_c;
                caddr = t[CAW-1:0];
            end
            S_CH_B: begin
                t = CW'(r_b) + lo_c;
                caddr = t[CAW-1:0];
            end
            S_EVAL: begin
                haddr = r_n;
                t = n_c;
                caddr = t[CAW-1:0];
            end
            default: begin
                t = n_c;
                caddr = t[CAW-1:0];
            end
        endcase
    end

    always_comb begin
        logic [CW-1:0] t;
        t = n_c + CW'(1);
        hwe    = (r_state == S_EVAL) && (r_mode == rhsc_pkg::MODE_APPEND);
        cwe    = hwe;
        hwdata = {chsum_l[HW-1:0], chsum_h[HW-1:0], r_acc[2], r_acc[3]};
        n_n    = r_n;
        if (hwe) begin
            n_n = t[LW-1:0];
        end else if (accept && (i_mode == rhsc_pkg::MODE_APPEND) && i_restart) begin
            n_n = '0;
        end
    end

    always_comb begin
        logic [CW-1:0] na;
        logic [CW-1:0] t;
        na = i_restart ? '0 : n_c;
        t  = '0;
        n_state = r_state;
        n_mode = r_mode;
        n_ch = r_ch;
        n_a = r_a;
        n_b = r_b;
        n_len = r_len;
        n_lo = r_lo;
        n_hi = r_hi;
        n_span = r_span;
        n_cnt = r_cnt;
        n_pw_l = r_pw_l;
        n_pw_h = r_pw_h;
        n_ha_l = r_ha_l;
        n_ha_h = r_ha_h;
        n_hb_l = r_hb_l;
        n_hb_h = r_hb_h;
        n_hal_l = r_hal_l;
        n_hal_h = r_hal_h;
        n_hbl_l = r_hbl_l;
        n_hbl_h = r_hbl_h;
        n_acc = r_acc;
        n_mpl = r_mpl;
        n_mcd = r_mcd;
        n_ca = r_ca;
        n_valid = 1'b0;
        n_order = r_order;
        n_lcp = r_lcp;
        n_hl = r_hl;
        n_hh = r_hh;
        n_eq = r_eq;
        n_err = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = i_mode;
                    n_ch = i_char_in;
                    n_a = a_c[LW-1:0];
                    n_b = b_c[LW-1:0];
                    n_order = rhsc_pkg::ORD_LESS;
                    n_lcp = '0;
                    n_hl = '0;
                    n_hh = '0;
                    n_eq = 1'b0;
                    n_err = 1'b0;
                    unique case (i_mode)
                        rhsc_pkg::MODE_APPEND: begin
                            if (na >= MAX_C) begin
                                n_valid = 1'b1;
                                n_err = 1'b1;
                            end else begin
                                n_state = S_APP_RD;
                            end
                        end
                        rhsc_pkg::MODE_CMP: begin
                            if (a_c > n_c || b_c > n_c) begin
                                n_valid = 1'b1;
                                n_err = 1'b1;
                            end else begin
                                t = n_c - mx_c;
                                n_span = t[LW-1:0];
                                n_lo = '0;
                                n_hi = t[LW-1:0];
                                n_state = S_BS;
                            end
                        end
                        rhsc_pkg::MODE_SUB: begin
                            if (a_c + sl_c > n_c || b_c + sl_c > n_c) begin
                                n_valid = 1'b1;
                                n_err = 1'b1;
                            end else begin
                                n_len = sl_c[LW-1:0];
                                n_state = S_RD_PW;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                            n_err = 1'b1;
                        end
                    endcase
                end
            end
            S_APP_RD: n_state = S_APP_LD;
            S_APP_LD: begin
                n_mpl[0] = q_ph_l;
                n_mpl[1] = q_ph_h;
                n_mpl[2] = q_pw_l;
                n_mpl[3] = q_pw_h;
                n_mcd[0] = base_l;
                n_mcd[1] = base_h;
                n_mcd[2] = base_l;
                n_mcd[3] = base_h;
                for (int l = 0; l < NL; l++) begin
                    n_acc[l] = '0;
                end
                n_cnt = '0;
                n_state = S_MUL;
            end
            S_RD_PW: n_state = S_RD_HA;
            S_RD_HA: begin
                n_pw_l = q_pw_l;
                n_pw_h = q_pw_h;
                n_state = S_RD_HB;
            end
            S_RD_HB: begin
                n_ha_l = q_ph_l;
                n_ha_h = q_ph_h;
                n_state = S_RD_HAL;
            end
            S_RD_HAL: begin
                n_hb_l = q_ph_l;
                n_hb_h = q_ph_h;
                n_state = S_RD_HBL;
            end
            S_RD_HBL: begin
                n_hal_l = q_ph_l;
                n_hal_h = q_ph_h;
                n_state = S_MUL_LD;
            end
            S_MUL_LD: begin
                n_hbl_l = q_ph_l;
                n_hbl_h = q_ph_h;
                n_mpl[0] = r_ha_l;
                n_mpl[1] = r_ha_h;
                n_mpl[2] = r_hb_l;
                n_mpl[3] = r_hb_h;
                n_mcd[0] = r_pw_l;
                n_mcd[1] = r_pw_h;
                n_mcd[2] = r_pw_l;
                n_mcd[3] = r_pw_h;
                for (int l = 0; l < NL; l++) begin
                    n_acc[l] = '0;
                end
                n_cnt = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_acc = step_acc;
                n_mpl = step_mpl;
                n_cnt = r_cnt + KW'(1);
                if (r_cnt == KW'(rhsc_pkg::MUL_CYC - 1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (r_mode)
                    rhsc_pkg::MODE_APPEND: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                    rhsc_pkg::MODE_SUB: begin
                        n_valid = 1'b1;
                        n_hl = sa_l;
                        n_hh = sa_h;
                        n_eq = all_eq;
                        n_state = S_IDLE;
                    end
                    default: begin
                        if (all_eq) begin
                            n_lo = r_len;
                        end else begin
                            n_hi = r_len - LW'(1);
                        end
                        n_state = S_BS;
                    end
                endcase
            end
            S_BS: begin
                if (r_lo < r_hi) begin
                    t = lo_c + hi_c + CW'(1);
                    n_len = t[LW:1];
                    n_state = S_RD_PW;
                end else if (r_lo < r_span) begin
                    n_state = S_CH_A;
                end else begin
                    n_valid = 1'b1;
                    n_lcp = lo_c[10:0];
                    n_order = (r_a > r_b) ? rhsc_pkg::ORD_LESS :
                              (r_a < r_b) ? rhsc_pkg::ORD_GT : rhsc_pkg::ORD_EQ;
                    n_state = S_IDLE;
                end
            end
            S_CH_A: n_state = S_CH_B;
            S_CH_B: begin
                n_ca = r_cq;
                n_state = S_CH_CMP;
            end
            S_CH_CMP: begin
                n_valid = 1'b1;
                n_lcp = lo_c[10:0];
                n_order = (r_ca < r_cq) ? rhsc_pkg::ORD_LESS :
                          (r_ca > r_cq) ? rhsc_pkg::ORD_GT : rhsc_pkg::ORD_EQ;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            hmem[haddr + LW'(1)] <= hwdata;
        end
        r_hq <= hmem[haddr];
        r_hq_zero <= (haddr == '0);
        if (cwe) begin
            cmem[caddr] <= r_ch;
        end
        r_cq <= cmem[caddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= rhsc_pkg::BASE_RESET;
            r_n     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_valid <= n_valid;
            if (cfg_wr && pready && (paddr[2] == rhsc_pkg::REG_HASH_BASE)) begin
                r_base <= pwdata[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_ch <= n_ch;
        r_a <= n_a;
        r_b <= n_b;
        r_len <= n_len;
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_span <= n_span;
        r_cnt <= n_cnt;
        r_pw_l <= n_pw_l;
        r_pw_h <= n_pw_h;
        r_ha_l <= n_ha_l;
        r_ha_h <= n_ha_h;
        r_hb_l <= n_hb_l;
        r_hb_h <= n_hb_h;
        r_hal_l <= n_hal_l;
        r_hal_h <= n_hal_h;
        r_hbl_l <= n_hbl_l;
        r_hbl_h <= n_hbl_h;
        r_acc <= n_acc;
        r_mpl <= n_mpl;
        r_mcd <= n_mcd;
        r_ca <= n_ca;
        r_order <= n_order;
        r_lcp <= n_lcp;
        r_hl <= n_hl;
        r_hh <= n_hh;
        r_eq <= n_eq;
        r_err <= n_err;
    end

endmodule
